// ===== rtl/core/nbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nbs_pkg;

  localparam int STATES       = 16;
  localparam int SYMBOL_COUNT = 256;

  localparam int STATE_W  = $clog2(STATES);
  localparam int SYMBOL_W = $clog2(SYMBOL_COUNT);
  localparam int TOKEN_W  = 5;
  localparam int ADDR_W   = STATE_W + SYMBOL_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // item modes
  localparam logic [1:0] MODE_TRANS = 2'd0;
  localparam logic [1:0] MODE_TOKEN = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STEP  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTING = CFG_IDX_W'(1);

  localparam logic [SYMBOL_W-1:0] SYM_EPSILON = '0;

  typedef logic [STATES-1:0] state_set_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [STATE_W-1:0]  state_index;
    logic [SYMBOL_W-1:0] symbol;
    state_set_t          target_set;
    logic [TOKEN_W-1:0]  token_value;
  } nbs_in_t;

  typedef struct packed {
    state_set_t         active_set;
    logic               accepted;
    logic               dead;
    logic [TOKEN_W-1:0] token_out;
  } nbs_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/nfa_bitset_simulator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// NFA simulator with epsilon closure. Every word taken on start (start high,
// busy low) returns exactly one result word on res_o, marked by a one-cycle
// done_o pulse; the receiver cannot stall and must take it in that cycle.
// Transition and token writes hold busy only through the report state. A
// start word runs one epsilon closure; a step word runs a closure of the
// active set, a move on the symbol, and a closure of the targets, while a
// step on an empty set goes straight to the report. Each pass reads the
// transition memory once per state it visits, one read per cycle while
// states are pending, and the data of a read comes back in the next cycle:
// reads run back to back when all states of a pass are known up front (a
// move always is), and a closure waits on each read when each state is only
// reached through the read before it. Busy covers the passes plus the report
// state, and done_o rises in the same cycle that busy drops. The transition
// memory has a single port and 4096 words. After reset the block runs a
// clearing pass over that memory with busy high; configuration writes are
// taken at any time (cfg_ready_o is always high) but must only be issued
// while the block is idle.
module nfa_bitset_simulator import nbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  nbs_in_t               in_i,
  output logic                  busy,
  output logic                  done_o,
  output nbs_out_t              res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_CLOSE_A = 3'd2; // closure ahead of a move
  localparam logic [2:0] ST_MOVE    = 3'd3;
  localparam logic [2:0] ST_CLOSE_B = 3'd4; // final closure
  localparam logic [2:0] ST_REPORT  = 3'd5;

  localparam logic [ADDR_W-1:0] ADDR_LAST = '1;

  logic [2:0]          state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  state_set_t          pend_q, pend_d;   // states still to be read
  state_set_t          acc_q, acc_d;     // set being built by the pass
  state_set_t          active_q, active_d;
  logic                rd_vld_q, rd_vld_d;
  logic [SYMBOL_W-1:0] sym_q;

  logic [STATE_W-1:0]  init_q;
  state_set_t          mask_q;
  logic [TOKEN_W-1:0]  tok_q [STATES];

  nbs_out_t            res_q, res_d;
  logic                done_q;

  // transition memory, address {state, symbol}
  state_set_t          mem [2**ADDR_W];
  state_set_t          rdata_q;
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  state_set_t          mem_wdata;

  logic                accept;
  logic                in_pass;
  logic                pend_any;
  logic                issue;
  logic [STATE_W-1:0]  pick_idx;
  state_set_t          pick_oh;
  logic [SYMBOL_W-1:0] rd_sym;
  state_set_t          hits;
  logic [TOKEN_W-1:0]  tok_sel;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = res_q;

  // lowest pending state is read next
  always_comb begin
    pick_idx = '0;
    for (int i = STATES - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        pick_idx = STATE_W'(i);
      end
    end
  end

  assign pick_oh  = state_set_t'(1) << pick_idx;
  assign pend_any = |pend_q;
  assign in_pass  = (state_q == ST_CLOSE_A) || (state_q == ST_MOVE) ||
                    (state_q == ST_CLOSE_B);
  assign issue    = in_pass && pend_any;
  assign rd_sym   = (state_q == ST_MOVE) ? sym_q : SYM_EPSILON;

  // memory port: clearing sweep, transition write, or pass read
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = {pick_idx, rd_sym};
    if (state_q == ST_CLEAR) begin
      mem_we   = 1'b1;
      mem_addr = clr_q;
    end else if (accept && (in_i.mode == MODE_TRANS)) begin
      mem_we    = 1'b1;
      mem_wdata = in_i.target_set;
      mem_addr  = {in_i.state_index, in_i.symbol};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    pend_d   = pend_q;
    acc_d    = acc_q;
    active_d = active_q;
    rd_vld_d = issue;
    if (issue) begin
      pend_d = pend_q & ~pick_oh;
    end
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_i.mode) inside
            MODE_TRANS, MODE_TOKEN: begin
              state_d = ST_REPORT;
            end
            MODE_START: begin
              acc_d   = state_set_t'(1) << init_q;
              pend_d  = state_set_t'(1) << init_q;
              state_d = ST_CLOSE_B;
            end
            MODE_STEP: begin
              if (active_q != '0) begin
                acc_d   = active_q;
                pend_d  = active_q;
                state_d = ST_CLOSE_A;
              end else begin
                state_d = ST_REPORT;
              end
            end
            default: state_d = ST_REPORT;
          endcase
        end
      end
      ST_CLOSE_A, ST_CLOSE_B: begin
        if (rd_vld_q) begin
          acc_d  = acc_q | rdata_q;
          pend_d = pend_d | (rdata_q & ~acc_q); // newly reached states
        end
        if (!pend_any && !rd_vld_q) begin
          if (state_q == ST_CLOSE_A) begin
            pend_d  = acc_q;
            acc_d   = '0;
            state_d = ST_MOVE;
          end else begin
            active_d = acc_q;
            state_d  = ST_REPORT;
          end
        end
      end
      ST_MOVE: begin
        if (rd_vld_q) begin
          acc_d = acc_q | rdata_q;
        end
        if (!pend_any && !rd_vld_q) begin
          pend_d  = acc_q;
          state_d = ST_CLOSE_B;
        end
      end
      ST_REPORT: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      pend_q   <= '0;
      acc_q    <= '0;
      active_q <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pend_q   <= pend_d;
      acc_q    <= acc_d;
      active_q <= active_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= (state_q == ST_REPORT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q <= in_i.symbol;
    end
  end

  // configuration and token store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      mask_q <= '0;
      for (int i = 0; i < STATES; i++) begin
        tok_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_INITIAL:   init_q <= cfg_data_i[STATE_W-1:0];
          CFG_ACCEPTING: mask_q <= cfg_data_i[STATES-1:0];
          default: ;
        endcase
      end
      if (accept && (in_i.mode == MODE_TOKEN)) begin
        tok_q[in_i.state_index] <= in_i.token_value;
      end
    end
  end

  // result: highest accepting active state with a token wins
  assign hits = active_q & mask_q;

  always_comb begin
    tok_sel = '0;
    for (int i = 0; i < STATES; i++) begin
      if (hits[i] && (tok_q[i] != '0)) begin
        tok_sel = tok_q[i];
      end
    end
    res_d.active_set = active_q;
    res_d.accepted   = |hits;
    res_d.dead       = (active_q == '0);
    res_d.token_out  = tok_sel;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_REPORT) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nbs_checker import nbs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     done_o,
  input nbs_out_t res_o
);

  // an accepted word always leaves the block busy, with no result strobe, in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("word accepted but block not busy next cycle");

  // results come out only once the block is idle again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.dead == (res_o.active_set == '0)))
    else $error("dead flag disagrees with active set");

  a_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.token_out != '0)) |-> (res_o.accepted && !res_o.dead))
    else $error("token reported without an accepting state");

endmodule

bind nfa_bitset_simulator nbs_checker u_nbs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire

// ===== tb/nfa_result_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and register channels of the NFA simulator,
// keeps its own copy of the automaton and predicts every result word.
module nfa_result_checker import nbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  nbs_in_t               in_i,
  input  logic                  done_i,
  input  nbs_out_t              res_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  state_set_t         nfa_transitions [STATES][SYMBOL_COUNT];
  logic [TOKEN_W-1:0] token_of [STATES];
  state_set_t         live_set;
  logic [STATE_W-1:0] start_state;
  state_set_t         accept_mask;

  nbs_out_t expected_words [$];
  nbs_out_t want;
  int       fail_cnt;
  int       pending_cnt;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;

  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    $display("[%0t] %s: want %0h, got %0h", $time, what, exp_val, got_val);
    fail_cnt++;
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (exp_val !== got_val) report_mismatch(what, exp_val, got_val);
  endtask

  function automatic state_set_t eps_close(input state_set_t seed);
    state_set_t cur;
    state_set_t grown;
    cur = seed;
    for (int pass = 0; pass < STATES; pass++) begin
      grown = cur;
      for (int s = 0; s < STATES; s++)
        if (cur[s]) grown |= nfa_transitions[s][SYM_EPSILON];
      if (grown == cur) break;
      cur = grown;
    end
    return cur;
  endfunction

  function automatic state_set_t move_on(input state_set_t src,
                                         input logic [SYMBOL_W-1:0] sym);
    state_set_t dst;
    dst = '0;
    for (int s = 0; s < STATES; s++)
      if (src[s]) dst |= nfa_transitions[s][sym];
    return dst;
  endfunction

  // Applies one word to the shadow automaton and returns the result it causes.
  function automatic nbs_out_t predict_result(input nbs_in_t w);
    nbs_out_t   r;
    state_set_t hits;
    logic [TOKEN_W-1:0] tok;
    case (w.mode)
      MODE_TRANS: nfa_transitions[w.state_index][w.symbol] = w.target_set;
      MODE_TOKEN: token_of[w.state_index] = w.token_value;
      MODE_START: live_set = eps_close(state_set_t'(1) << start_state);
      default: begin
        // an empty set stays empty
        if (live_set != '0)
          live_set = eps_close(move_on(eps_close(live_set), w.symbol));
      end
    endcase
    hits = live_set & accept_mask;
    tok  = '0;
    // highest-numbered accepting state with a token wins
    for (int s = 0; s < STATES; s++)
      if (hits[s] && token_of[s] != '0) tok = token_of[s];
    r.active_set = live_set;
    r.accepted   = (hits != '0);
    r.dead       = (live_set == '0);
    r.token_out  = tok;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STATES; s++) begin
        token_of[s] = '0;
        for (int c = 0; c < SYMBOL_COUNT; c++) nfa_transitions[s][c] = '0;
      end
      live_set    = '0;
      start_state = '0;
      accept_mask = '0;
      expected_words.delete();
      fail_cnt    = 0;
      pending_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_INITIAL:   start_state = cfg_data_i[STATE_W-1:0];
          CFG_ACCEPTING: accept_mask = cfg_data_i[STATES-1:0];
          default: ;
        endcase
      end
      if (done_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing pending", '0, 32'(res_i));
        end else begin
          want = expected_words.pop_front();
          check_field("active_set", 32'(want.active_set), 32'(res_i.active_set));
          check_field("accepted", 32'(want.accepted), 32'(res_i.accepted));
          check_field("dead", 32'(want.dead), 32'(res_i.dead));
          check_field("token_out", 32'(want.token_out), 32'(res_i.token_out));
        end
      end
      if (start_i && !busy_i) expected_words.push_back(predict_result(in_i));
      pending_cnt = expected_words.size();
    end
  end

endmodule

// ===== tb/tb_nfa_bitset_simulator.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the NFA simulator. The checker beside the block
// does all prediction; this module only feeds words, writes registers while
// the block is quiet, and decides pass/fail at the end.
module tb_nfa_bitset_simulator;
  import nbs_pkg::*;

  localparam int RANDOM_TARGET = 390;     // directed + random words
  localparam int DRAIN_CYCLES  = 64;      // slack after the last result
  localparam int CYCLE_LIMIT   = 500000;  // clearing pass + slow run, many times over

  logic clk = 1'b0;
  logic rst_n;

  // item channel
  logic     start;
  nbs_in_t  in_word;
  logic     busy;
  logic     done;
  nbs_out_t res_word;

  // register channel
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_cnt;
  int words_sent;
  int cycle_cnt = 0;
  bit steady;       // phase without sender gaps

  always #2 clk = ~clk;

  nfa_bitset_simulator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .in_i        (in_word),
    .busy        (busy),
    .done_o      (done),
    .res_o       (res_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  nfa_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .in_i         (in_word),
    .done_i       (done),
    .res_i        (res_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_cnt)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_nfa_bitset_simulator: errors");
      $finish;
    end
  end

  function automatic nbs_in_t make_word(input logic [1:0] m, input logic [STATE_W-1:0] idx,
                                        input logic [SYMBOL_W-1:0] sym,
                                        input state_set_t nxt,
                                        input logic [TOKEN_W-1:0] tok);
    nbs_in_t w;
    w.mode        = m;
    w.state_index = idx;
    w.symbol      = sym;
    w.target_set  = nxt;
    w.token_value = tok;
    return w;
  endfunction

  function automatic nbs_in_t rand_word();
    return make_word(2'($urandom_range(0, 3)), STATE_W'($urandom_range(0, STATES - 1)),
                     SYMBOL_W'($urandom_range(0, SYMBOL_COUNT - 1)),
                     state_set_t'($urandom), TOKEN_W'($urandom_range(0, 31)));
  endfunction

  // Mostly one or two targets so closures stay interesting, sometimes
  // empty or dense.
  function automatic state_set_t sparse_set();
    int r;
    state_set_t s;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 25) return state_set_t'($urandom);
    s = state_set_t'(1) << $urandom_range(0, STATES - 1);
    if (r < 60) s |= state_set_t'(1) << $urandom_range(0, STATES - 1);
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // Holds the word until the block takes it, then idles a random gap.
  // With no gap start stays high and the next call changes the word.
  task automatic send_item(input nbs_in_t w);
    int gap;
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start   <= 1'b0;
      in_word <= rand_word();   // ignored while start is low
    end
  endtask

  // Drops start and waits until every result word is back and busy is low.
  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (pending_cnt != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [SYMBOL_W-1:0] sym_pool [3];
    logic [SYMBOL_W-1:0] sym;
    int phase;
    int r;
    int n;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    words_sent = 0;
    steady     = 1'b0;
    phase      = 0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // ---------------- directed part ----------------
    // write_reg waits out the clearing pass (busy high after reset)
    write_reg(CFG_INITIAL, 16'd0);
    write_reg(CFG_ACCEPTING, 16'hFFFF);

    // step before any start: empty set stays empty
    send_item(make_word(MODE_STEP, 4'd15, 8'hFF, 16'hFFFF, 5'd31));
    // start with empty tables: just the initial state
    send_item(make_word(MODE_START, 4'd0, 8'd0, 16'h0000, 5'd0));
    send_item(make_word(MODE_TRANS, 4'd0, SYM_EPSILON, 16'h0002, 5'd31));  // 0 -e-> 1
    send_item(make_word(MODE_TRANS, 4'd1, 8'hFF, 16'hFFFF, 5'd0));         // 1 -FF-> all
    send_item(make_word(MODE_TRANS, 4'd15, SYM_EPSILON, 16'h0001, 5'd0));  // 15 -e-> 0
    send_item(make_word(MODE_TRANS, 4'd15, 8'hFF, 16'h0000, 5'd31));
    send_item(make_word(MODE_TOKEN, 4'd15, 8'hFF, 16'hFFFF, 5'd31));
    send_item(make_word(MODE_TOKEN, 4'd1, 8'd0, 16'h0000, 5'd1));
    send_item(make_word(MODE_TOKEN, 4'd0, 8'd0, 16'h0000, 5'd0));
    // start closes over epsilon: {0,1}
    send_item(make_word(MODE_START, 4'd15, 8'hFF, 16'hFFFF, 5'd31));
    // full set, highest token wins
    send_item(make_word(MODE_STEP, 4'd0, 8'hFF, 16'h0000, 5'd0));
    // step on epsilon follows epsilon targets as an ordinary move
    send_item(make_word(MODE_STEP, 4'd0, SYM_EPSILON, 16'h0000, 5'd0));
    // no targets on this byte: set dies, then stays dead
    send_item(make_word(MODE_STEP, 4'd3, 8'h80, 16'h1234, 5'd7));
    send_item(make_word(MODE_STEP, 4'd3, 8'hFF, 16'h1234, 5'd7));
    send_item(make_word(MODE_START, 4'd0, 8'd0, 16'h0000, 5'd0));
    send_item(make_word(MODE_TRANS, 4'd0, SYM_EPSILON, 16'h0000, 5'd0));
    // other extreme of the registers
    write_reg(CFG_INITIAL, 16'd15);
    write_reg(CFG_ACCEPTING, 16'h8000);
    send_item(make_word(MODE_START, 4'd0, 8'd0, 16'h0000, 5'd0));    // {0,15}
    send_item(make_word(MODE_TOKEN, 4'd15, 8'd0, 16'h0000, 5'd0));   // accepted, no token
    send_item(make_word(MODE_STEP, 4'd0, 8'hFF, 16'h0000, 5'd0));    // dies
    write_reg(CFG_ACCEPTING, 16'h0000);
    send_item(make_word(MODE_START, 4'd0, 8'd0, 16'h0000, 5'd0));

    // ---------------- random phases ----------------
    while (words_sent < RANDOM_TARGET) begin
      phase++;
      steady = ($urandom_range(0, 3) == 0);

      // register settings: alternate extremes with random picks
      case (phase % 4)
        0: begin
          write_reg(CFG_INITIAL, 16'd0);
          write_reg(CFG_ACCEPTING, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_INITIAL, 16'd15);
          write_reg(CFG_ACCEPTING, 16'h0000);
        end
        default: begin
          write_reg(CFG_INITIAL, 16'($urandom_range(0, STATES - 1)));
          write_reg(CFG_ACCEPTING,
                    ($urandom_range(0, 1) == 1) ? 16'(sparse_set()) : 16'($urandom));
        end
      endcase

      if ($urandom_range(0, 5) == 0) begin
        // noise phase: unstructured words
        repeat (20) send_item(rand_word());
      end else begin
        // small alphabet so steps actually hit written transitions
        foreach (sym_pool[i]) sym_pool[i] = SYMBOL_W'($urandom_range(1, SYMBOL_COUNT - 1));

        n = $urandom_range(4, 10);
        repeat (n) begin
          sym = ($urandom_range(0, 3) == 0) ? SYM_EPSILON : sym_pool[$urandom_range(0, 2)];
          send_item(make_word(MODE_TRANS, STATE_W'($urandom_range(0, STATES - 1)), sym,
                              sparse_set(), TOKEN_W'($urandom_range(0, 31))));
        end
        n = $urandom_range(1, 4);
        repeat (n)
          send_item(make_word(MODE_TOKEN, STATE_W'($urandom_range(0, STATES - 1)),
                              SYMBOL_W'($urandom), state_set_t'($urandom),
                              TOKEN_W'($urandom_range(0, 31))));

        send_item(make_word(MODE_START, STATE_W'($urandom), SYMBOL_W'($urandom),
                            state_set_t'($urandom), TOKEN_W'($urandom)));

        n = $urandom_range(4, 14);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            send_item(make_word(MODE_START, STATE_W'($urandom), SYMBOL_W'($urandom),
                                state_set_t'($urandom), TOKEN_W'($urandom)));
          end else if (r < 13) begin
            send_item(rand_word());
          end else begin
            if (r < 80)      sym = sym_pool[$urandom_range(0, 2)];
            else if (r < 90) sym = SYM_EPSILON;
            else             sym = SYMBOL_W'($urandom_range(0, SYMBOL_COUNT - 1));
            send_item(make_word(MODE_STEP, STATE_W'($urandom), sym,
                                state_set_t'($urandom), TOKEN_W'($urandom)));
          end
        end
      end

      // occasional hold-off until the block has drained
      if ($urandom_range(0, 4) == 0) wait_quiet();
    end

    // ---------------- wind-down ----------------
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_nfa_bitset_simulator: clean");
    end else begin
      $display("tb_nfa_bitset_simulator: errors");
    end
    $finish;
  end

endmodule

// ===== nfa_bitset_simulator.f =====
rtl/core/nbs_pkg.sv
rtl/core/nfa_bitset_simulator.sv
rtl/core/nbs_checker.sv
tb/nfa_result_checker.sv
tb/tb_nfa_bitset_simulator.sv
